/* design/iptb_pkg.sv */
// ----------------------------------------------------------------------------
// iptb_pkg
// Shared types and constants of the identity page table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package iptb_pkg;

  localparam int unsigned NumPagesDefault     = 12;
  localparam int unsigned PhysAddrBitsDefault = 46;
  localparam int unsigned EntriesPerPage      = 512;

  localparam logic [1:0] StatusDone     = 2'd0;
  localparam logic [1:0] StatusNoPages  = 2'd1;
  localparam logic [1:0] StatusReadData = 2'd2;

  localparam logic       FuncMap  = 1'b0;
  localparam logic       FuncRead = 1'b1;

  localparam logic       CfgLeafFlags = 1'b0;
  localparam logic       CfgPoolBase  = 1'b1;

  localparam logic [11:0] DirFlags    = 12'h063;
  localparam logic [11:0] LeafBusy    = 12'h181;
  localparam logic [11:0] LeafFlagsRst = 12'd483;

  typedef struct packed {
    logic        func;
    logic [45:0] range_start;
    logic [45:0] range_size;
    logic [3:0]  page_index;
    logic [8:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] entry_value;
    logic [3:0]  pages_used;
  } rsp_t;

endpackage

`default_nettype wire

/* design/identity_page_table_builder.sv */
// ----------------------------------------------------------------------------
// identity_page_table_builder
// Builds three-level identity page tables with 2 MB leaves in a page pool.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. A read item
// addresses its entry in the idle state and gives its result through the read
// state. A map item walks the root, directory and leaf levels in one table
// memory with a single read port and a single write port; each leaf visit
// reads its entry, then writes it if no busy flag is set; each directory
// visit reads and checks its entry; each page taken from the pool is zeroed.
// The result appears for exactly one cycle with done_o high; the receiver
// cannot hold it off, and the next item may be started in that same cycle.
// After reset the whole table memory is zeroed, and busy_o stays high during
// that pass. Configuration writes are taken on the cfg channel at any time but
// are meant to be issued while the block is idle.
`default_nettype none

module identity_page_table_builder
  import iptb_pkg::*;
#(
  parameter int unsigned NUM_PAGES      = NumPagesDefault,
  parameter int unsigned PHYS_ADDR_BITS = PhysAddrBitsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire req_t   req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [31:0] cfg_data_i
);

  localparam int unsigned PW    = $clog2(NUM_PAGES);
  localparam int unsigned PCW   = $clog2(NUM_PAGES + 1);
  localparam int unsigned AW    = PW + 9;
  localparam int unsigned DEPTH = NUM_PAGES * EntriesPerPage;
  localparam int unsigned WW    = (PHYS_ADDR_BITS + 1 > 48) ? PHYS_ADDR_BITS + 1 : 48;
  localparam int unsigned FW    = PHYS_ADDR_BITS - 12;

  localparam logic [WW-1:0] One    = {{(WW-1){1'b0}}, 1'b1};
  localparam logic [WW-1:0] Cap    = One << PHYS_ADDR_BITS;
  localparam logic [WW-1:0] Sz2M   = One << 21;
  localparam logic [WW-1:0] Sz1G   = One << 30;
  localparam logic [WW-1:0] Sz512G = One << 39;
  localparam logic [WW-1:0] Low4G  = One << 32;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_OWN   = 4'd3;
  localparam logic [3:0] S_RLOOP = 4'd4;
  localparam logic [3:0] S_RCHK  = 4'd5;
  localparam logic [3:0] S_MLOOP = 4'd6;
  localparam logic [3:0] S_MCHK  = 4'd7;
  localparam logic [3:0] S_LRD   = 4'd8;
  localparam logic [3:0] S_LCHK  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]     state_q, state_d, ret_q, ret_d;
  logic [AW-1:0]  clr_q, clr_d, clr_end_q, clr_end_d;
  logic [PCW-1:0] pa_q, pa_d;
  logic           root_q, root_d, fail_q, fail_d, own_q, own_d;
  logic           rnew_q, rnew_d, mnew_q, mnew_d;
  logic [PW-1:0]  rsub_q, rsub_d, lpage_q, lpage_d;
  logic [WW-1:0]  ostart_q, ostart_d, oend_q, oend_d;
  logic [WW-1:0]  raddr_q, raddr_d, rend_q, rend_d, rnext_q, rnext_d;
  logic [WW-1:0]  maddr_q, maddr_d, mnext_q, mnext_d;
  logic [WW-1:0]  laddr_q, laddr_d;
  logic [11:0]    flags_q;
  logic [31:0]    pbase_q;
  logic           rdin_q, rdin_d;
  logic           done_q, done_d;
  rsp_t           rsp_q, rsp_d;

  logic [63:0]    mem_q [DEPTH];
  logic [63:0]    rd_q;
  logic           we;
  logic [AW-1:0]  wa, ra;
  logic [63:0]    wd;

  logic [FW:0]    diff;
  logic           fvalid;
  logic [PW-1:0]  fsub;
  logic [46:0]    sum;
  logic [47:0]    eround;
  logic [WW-1:0]  ealign, tmp, nxt;
  logic           full;

  assign diff   = {1'b0, rd_q[PHYS_ADDR_BITS-1:12]} - (FW+1)'(pbase_q[31:12]);
  assign fvalid = !diff[FW] && (diff < (FW+1)'(NUM_PAGES));
  assign fsub   = diff[PW-1:0];
  assign full   = (pa_q >= PCW'(NUM_PAGES));

  function automatic logic [63:0] dir_entry(input logic [31:0] base, input logic [PW-1:0] p);
    dir_entry = (64'({base[31:12], 12'b0}) + 64'({p, 12'b0})) | 64'(DirFlags);
  endfunction

  always_comb begin
    state_d = state_q; ret_d = ret_q; clr_d = clr_q; clr_end_d = clr_end_q;
    pa_d = pa_q; root_d = root_q; fail_d = fail_q; own_d = own_q;
    rnew_d = rnew_q; mnew_d = mnew_q; rsub_d = rsub_q; lpage_d = lpage_q;
    ostart_d = ostart_q; oend_d = oend_q; raddr_d = raddr_q; rend_d = rend_q;
    rnext_d = rnext_q; maddr_d = maddr_q; mnext_d = mnext_q; laddr_d = laddr_q;
    rdin_d = rdin_q; done_d = 1'b0; rsp_d = rsp_q;
    we = 1'b0; wa = '0; wd = '0; ra = '0;
    sum = 47'(req_i.range_start) + 47'(req_i.range_size);
    eround = 48'(sum) + 48'(Sz2M - One);
    ealign = WW'({eround[47:21], 21'b0});
    tmp = '0; nxt = '0;
    unique case (state_q)
      S_CLR: begin
        we = 1'b1; wa = clr_q; wd = '0;
        if (clr_q == clr_end_q) state_d = ret_q;
        else clr_d = clr_q + AW'(1);
      end
      S_IDLE: begin
        ra = {PW'(req_i.page_index), req_i.entry_index};
        if (start_i) begin
          fail_d = 1'b0;
          if (req_i.func == FuncRead) begin
            rdin_d = (32'(req_i.page_index) < NUM_PAGES);
            state_d = S_RD;
          end else begin
            ostart_d = WW'({req_i.range_start[45:21], 21'b0});
            oend_d = (ealign > Cap) ? Cap : ealign;
            own_d = 1'b0;
            if (root_q) begin
              state_d = S_OWN;
            end else if (full) begin
              fail_d = 1'b1; state_d = S_OWN;
            end else begin
              root_d = 1'b1; pa_d = pa_q + PCW'(1);
              raddr_d = '0; rend_d = Low4G;
              clr_d = {pa_q[PW-1:0], 9'd0}; clr_end_d = {pa_q[PW-1:0], 9'h1ff};
              ret_d = S_RLOOP; state_d = S_CLR;
            end
          end
        end
      end
      S_RD: begin
        done_d = 1'b1;
        rsp_d.status = StatusReadData;
        rsp_d.entry_value = rdin_q ? rd_q : 64'd0;
        rsp_d.pages_used = 4'(pa_q);
        state_d = S_IDLE;
      end
      S_OWN: begin
        own_d = 1'b1;
        if (root_q && (ostart_q >= Low4G)) begin
          raddr_d = ostart_q; rend_d = oend_q; state_d = S_RLOOP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RLOOP: begin
        ra = {PW'(0), raddr_q[47:39]};
        if (raddr_q >= rend_q) begin
          state_d = own_q ? S_DONE : S_OWN;
        end else begin
          tmp = {raddr_q[WW-1:39], 39'b0} + Sz512G;
          rnext_d = (tmp > rend_q) ? rend_q : tmp;
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        maddr_d = raddr_q; rnew_d = 1'b0;
        if (rd_q[0]) begin
          if (fvalid) begin
            rsub_d = fsub; state_d = S_MLOOP;
          end else begin
            raddr_d = rnext_q; state_d = S_RLOOP;
          end
        end else if (full) begin
          fail_d = 1'b1; state_d = own_q ? S_DONE : S_OWN;
        end else begin
          rnew_d = 1'b1; rsub_d = pa_q[PW-1:0]; pa_d = pa_q + PCW'(1);
          clr_d = {pa_q[PW-1:0], 9'd0}; clr_end_d = {pa_q[PW-1:0], 9'h1ff};
          ret_d = S_MLOOP; state_d = S_CLR;
        end
      end
      S_MLOOP: begin
        ra = {rsub_q, maddr_q[38:30]};
        if (maddr_q >= rnext_q) begin
          if (rnew_q) begin
            we = 1'b1; wa = {PW'(0), raddr_q[47:39]}; wd = dir_entry(pbase_q, rsub_q);
          end
          raddr_d = rnext_q; state_d = S_RLOOP;
        end else begin
          nxt = {maddr_q[WW-1:30], 30'b0} + Sz1G;
          mnext_d = (nxt > rnext_q) ? rnext_q : nxt;
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        laddr_d = {maddr_q[WW-1:21], 21'b0}; mnew_d = 1'b0;
        if (rd_q[0]) begin
          if (fvalid) begin
            lpage_d = fsub; state_d = S_LRD;
          end else begin
            maddr_d = mnext_q; state_d = S_MLOOP;
          end
        end else if (full) begin
          fail_d = 1'b1; state_d = own_q ? S_DONE : S_OWN;
        end else begin
          mnew_d = 1'b1; lpage_d = pa_q[PW-1:0]; pa_d = pa_q + PCW'(1);
          clr_d = {pa_q[PW-1:0], 9'd0}; clr_end_d = {pa_q[PW-1:0], 9'h1ff};
          ret_d = S_LRD; state_d = S_CLR;
        end
      end
      S_LRD: begin
        ra = {lpage_q, laddr_q[29:21]};
        if (laddr_q >= mnext_q) begin
          if (mnew_q) begin
            we = 1'b1; wa = {rsub_q, maddr_q[38:30]}; wd = dir_entry(pbase_q, lpage_q);
          end
          maddr_d = mnext_q; state_d = S_MLOOP;
        end else begin
          state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        if ((rd_q[11:0] & LeafBusy) == 12'd0) begin
          we = 1'b1; wa = {lpage_q, laddr_q[29:21]};
          wd = 64'(laddr_q) | 64'(flags_q);
        end
        laddr_d = laddr_q + Sz2M; state_d = S_LRD;
      end
      S_DONE: begin
        done_d = 1'b1;
        rsp_d.status = fail_q ? StatusNoPages : StatusDone;
        rsp_d.entry_value = 64'd0;
        rsp_d.pages_used = 4'(pa_q);
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; ret_q <= S_IDLE; clr_q <= '0; clr_end_q <= AW'(DEPTH - 1);
      pa_q <= '0; root_q <= 1'b0; fail_q <= 1'b0; own_q <= 1'b0;
      rnew_q <= 1'b0; mnew_q <= 1'b0; rdin_q <= 1'b0; done_q <= 1'b0;
      flags_q <= LeafFlagsRst; pbase_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; clr_q <= clr_d; clr_end_q <= clr_end_d;
      pa_q <= pa_d; root_q <= root_d; fail_q <= fail_d; own_q <= own_d;
      rnew_q <= rnew_d; mnew_q <= mnew_d; rdin_q <= rdin_d; done_q <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgLeafFlags) flags_q <= cfg_data_i[11:0];
        else pbase_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsub_q <= rsub_d; lpage_q <= lpage_d; ostart_q <= ostart_d; oend_q <= oend_d;
    raddr_q <= raddr_d; rend_q <= rend_d; rnext_q <= rnext_d;
    maddr_q <= maddr_d; mnext_q <= mnext_d; laddr_q <= laddr_d; rsp_q <= rsp_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  a_pages_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pa_q <= PCW'(NUM_PAGES)) else $error("page count beyond pool");
  a_root_page : assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_q |-> (pa_q != '0)) else $error("root marked without a page");
  a_done_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d |-> (state_q == S_DONE || state_q == S_RD)) else $error("stray result");
  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !done_d) else $error("result held longer than one cycle");

endmodule

`default_nettype wire
